[rtl/twind_pkg.sv]
// Shared types and constants for the triangle winding order block.
package twind_pkg;

	localparam int IDX_W       = 2;
	localparam int OUT_TDATA_W = 8;

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t VTX_A = 2'd0;
	localparam idx_t VTX_B = 2'd1;
	localparam idx_t VTX_C = 2'd2;

	// top vertex, lower-z vertex of the pair (larger x on a z tie), other vertex, and
	// whether the pair order is already settled without the dot product
	typedef struct packed {
		idx_t top;
		idx_t m;
		idx_t o;
		logic fixed;
	} ord_t;

endpackage

[rtl/triangle_winding_order.sv]
// Triangle winding order: five-stage pipeline from vertex word to index word.
//
// One triangle word is taken per clock unless the pipeline is stalled, and
// its index word is registered in each stage in turn. The stages follow the
// dot product: each of its three multiplies is split into two narrower partial
// products in one stage and recombined in the next, and the sum and its sign
// test take the final stage. Each stage has its own valid bit, so empty
// stages fill while the output is held, and s_tready drops only when every
// stage is occupied and the output word is not taken.
module triangle_winding_order #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
	// vertex_c_x, vertex_c_y, vertex_c_z, then zero padding
	input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// first_index, second_index, third_index, then zero padding
	output logic [twind_pkg::OUT_TDATA_W-1:0]      m_tdata
);

	import twind_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int CW  = W + 1;
	localparam int LW  = CW / 2;
	localparam int HW  = CW - LW;
	localparam int PLW = CW + LW + 1;
	localparam int PHW = CW + HW;
	localparam int PW  = 2 * CW;
	localparam int SW  = PW + 2;

	// stage control
	logic vld_s1, vld_s2, vld_s3, vld_s4, out_vld_q;
	logic en1, en2, en3, en4, out_rdy;

	assign out_rdy  = !out_vld_q || m_tready;
	assign en4      = !vld_s4 || out_rdy;
	assign en3      = !vld_s3 || en4;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en1) vld_s1 <= s_tvalid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (out_rdy) out_vld_q <= vld_s4;
		end
	end

	// stage 1: input register
	logic [9*W-1:0] data_s1;
	logic signed [W-1:0] crd [9];

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) data_s1 <= s_tdata[9*W-1:0];
	end

	always_comb begin
		for (int k = 0; k < 9; k++) crd[k] = data_s1[k*W +: W];
	end

	// top selection and pair ordering
	logic ge_ab, ge_ac, ge_ba, ge_bc;
	logic signed [W-1:0] pz, qz, px, qx;
	logic signed [W-1:0] tx, ty, tz, mx, my, mz, ox, oy, oz;
	idx_t p, q;
	ord_t ord;

	assign ge_ab = crd[2] >= crd[5];
	assign ge_ac = crd[2] >= crd[8];
	assign ge_ba = crd[5] >= crd[2];
	assign ge_bc = crd[5] >= crd[8];

	always_comb begin
		if (ge_ab && ge_ac) begin
			ord.top = VTX_A;
			p       = VTX_B;
			q       = VTX_C;
			px      = crd[3];
			pz      = crd[5];
			qx      = crd[6];
			qz      = crd[8];
		end else if (ge_ba && ge_bc) begin
			ord.top = VTX_B;
			p       = VTX_A;
			q       = VTX_C;
			px      = crd[0];
			pz      = crd[2];
			qx      = crd[6];
			qz      = crd[8];
		end else begin
			ord.top = VTX_C;
			p       = VTX_A;
			q       = VTX_B;
			px      = crd[0];
			pz      = crd[2];
			qx      = crd[3];
			qz      = crd[5];
		end
		if (pz == qz) begin
			ord.fixed = 1'b1;
			if (px > qx) begin
				ord.m = p;
				ord.o = q;
			end else begin
				ord.m = q;
				ord.o = p;
			end
		end else if (pz > qz) begin
			ord.fixed = 1'b0;
			ord.m     = q;
			ord.o     = p;
		end else begin
			ord.fixed = 1'b0;
			ord.m     = p;
			ord.o     = q;
		end
	end

	always_comb begin
		case (ord.top)
			VTX_A: begin
				tx = crd[0]; ty = crd[1]; tz = crd[2];
			end
			VTX_B: begin
				tx = crd[3]; ty = crd[4]; tz = crd[5];
			end
			default: begin
				tx = crd[6]; ty = crd[7]; tz = crd[8];
			end
		endcase
		case (ord.m)
			VTX_A: begin
				mx = crd[0]; my = crd[1]; mz = crd[2];
			end
			VTX_B: begin
				mx = crd[3]; my = crd[4]; mz = crd[5];
			end
			default: begin
				mx = crd[6]; my = crd[7]; mz = crd[8];
			end
		endcase
		case (ord.o)
			VTX_A: begin
				ox = crd[0]; oy = crd[1]; oz = crd[2];
			end
			VTX_B: begin
				ox = crd[3]; oy = crd[4]; oz = crd[5];
			end
			default: begin
				ox = crd[6]; oy = crd[7]; oz = crd[8];
			end
		endcase
	end

	// stage 2: normal and offset components
	ord_t ord_s2;
	logic signed [CW-1:0] a_s2 [3];
	logic signed [CW-1:0] b_s2 [3];

	always_ff @(posedge clk) begin
		if (en2 && vld_s1) begin
			ord_s2  <= ord;
			a_s2[0] <= $signed({mz[W-1], mz}) - $signed({tz[W-1], tz});
			b_s2[0] <= $signed({ox[W-1], ox}) - $signed({mx[W-1], mx});
			a_s2[1] <= $signed({ty[W-1], ty}) - $signed({my[W-1], my});
			b_s2[1] <= $signed({oy[W-1], oy}) - $signed({my[W-1], my});
			a_s2[2] <= $signed({tx[W-1], tx}) - $signed({mx[W-1], mx});
			b_s2[2] <= $signed({oz[W-1], oz}) - $signed({mz[W-1], mz});
		end
	end

	// stage 3: partial products, offset split into a low and a high part
	ord_t ord_s3;
	logic signed [PLW-1:0] pl_s3 [3];
	logic signed [PHW-1:0] ph_s3 [3];

	always_ff @(posedge clk) begin
		if (en3 && vld_s2) begin
			ord_s3 <= ord_s2;
			for (int k = 0; k < 3; k++) begin
				pl_s3[k] <= a_s2[k] * $signed({1'b0, b_s2[k][LW-1:0]});
				ph_s3[k] <= a_s2[k] * $signed(b_s2[k][CW-1:LW]);
			end
		end
	end

	// stage 4: full products
	ord_t ord_s4;
	logic signed [PW-1:0] prod_s4 [3];

	always_ff @(posedge clk) begin
		if (en4 && vld_s3) begin
			ord_s4 <= ord_s3;
			for (int k = 0; k < 3; k++) begin
				prod_s4[k] <= ($signed({ph_s3[k], {LW{1'b0}}}))
					+ $signed({{(PW-PLW){pl_s3[k][PLW-1]}}, pl_s3[k]});
			end
		end
	end

	// output stage: sum, sign test and final order
	logic signed [SW-1:0] dot;
	logic                 take_m;
	logic [OUT_TDATA_W-1:0] tdata_d;
	logic [OUT_TDATA_W-1:0] tdata_q;

	assign dot = $signed({{2{prod_s4[0][PW-1]}}, prod_s4[0]})
		+ $signed({{2{prod_s4[1][PW-1]}}, prod_s4[1]})
		+ $signed({{2{prod_s4[2][PW-1]}}, prod_s4[2]});
	assign take_m = ord_s4.fixed || (!dot[SW-1] && (dot != '0));

	always_comb begin
		tdata_d = '0;
		tdata_d[IDX_W-1:0] = ord_s4.top;
		if (take_m) begin
			tdata_d[2*IDX_W-1:IDX_W]   = ord_s4.m;
			tdata_d[3*IDX_W-1:2*IDX_W] = ord_s4.o;
		end else begin
			tdata_d[2*IDX_W-1:IDX_W]   = ord_s4.o;
			tdata_d[3*IDX_W-1:2*IDX_W] = ord_s4.m;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && vld_s4) tdata_q <= tdata_d;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = tdata_q;

	// checks
	a_idx_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != m_tdata[3:2]) && (m_tdata[3:2] != m_tdata[5:4])
			&& (m_tdata[1:0] != m_tdata[5:4]))
		else $error("output indices not a permutation");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[3:2] != 2'd3)
			&& (m_tdata[5:4] != 2'd3))
		else $error("output index out of range");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> vld_s1 && vld_s2 && vld_s3 && vld_s4 && out_vld_q && !m_tready)
		else $error("input stalled with a free stage");

endmodule
